[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files that check their own logic.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/spef_pkg.sv]
// Shared types and fixed constants of the stereo predelay and level follower.
// No dependencies.
`timescale 1ns / 1ps
package spef_pkg;

	localparam int XGAIN_BITS = 14;
	localparam int ENV_BITS   = 40;
	localparam int ENV_FRAC   = 16;
	localparam int LEVEL_BITS = 24;

	// follower coefficients, Q24
	localparam logic signed [17:0] ATTACK_COEF  = 18'sd67109;
	localparam logic signed [17:0] RELEASE_COEF = 18'sd11744;

	// per-item strobes from the sequencer to the lanes and the follower
	typedef struct packed {
		logic       ph0;    // first read slot of an item
		logic       ph1;    // second read slot, store write, follower update
		logic       blend;  // interpolation multiply
		logic       ok0;    // earlier tap was written (valid in ph1)
		logic       ok1;    // later tap was written (valid in blend)
		logic [7:0] frac;   // interpolation fraction (valid in blend)
	} lane_ctl_t;

endpackage

[hw/rtl/spef_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module spef_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/spef_lane.sv]
// One delay channel: cross-feed push, two-tap read and linear interpolation.
// Depends on spef_pkg and spef_ram.
`timescale 1ns / 1ps
module spef_lane #(
	parameter int DEPTH = 32768,
	parameter int SB    = 24
) (
	input  logic                              clk,
	input  spef_pkg::lane_ctl_t               ctl,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic signed [SB-1:0]              x,
	input  logic signed [SB-1:0]              other,
	input  logic [spef_pkg::XGAIN_BITS-1:0]   gain,
	output logic signed [SB-1:0]              wet
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = SB + 16;
	localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [FW-1:0] SAT_LO = FW'(-(64'sd1 <<< (SB - 1)));
	localparam logic signed [FW-1:0] FEED_RND = FW'(64'sd32768);
	localparam logic signed [SB+10:0] BLEND_RND = (SB + 11)'(64'sd128);

	logic signed [SB:0]     fdiff;
	logic signed [FW-1:0]   fprod_w;
	logic signed [FW-1:0]   fprod_q;
	logic signed [FW-1:0]   frnd;
	logic signed [FW-1:0]   ft;
	logic signed [FW-1:0]   fsum;
	logic [SB-1:0]          wdata;
	logic [SB-1:0]          rdata;
	logic signed [SB-1:0]   s0m;
	logic signed [SB-1:0]   s1m;
	logic signed [SB-1:0]   s0_q;
	logic signed [SB:0]     bdiff;
	logic signed [SB+9:0]   bprod_w;
	logic signed [SB+9:0]   bprod_q;
	logic signed [SB-1:0]   base_q;
	logic signed [SB+10:0]  acc;
	logic [AW-1:0]          ra;

	// push value: x + round((x - other) * gain / 2^16), saturated
	assign fdiff   = $signed({x[SB-1], x}) - $signed({other[SB-1], other});
	assign fprod_w = fdiff * $signed({1'b0, gain});
	assign frnd    = fprod_q + FEED_RND;
	assign ft      = frnd >>> 16;
	assign fsum    = $signed({{16{x[SB-1]}}, x}) + ft;
	assign wdata   = (fsum > SAT_HI) ? SAT_HI[SB-1:0] :
			 (fsum < SAT_LO) ? SAT_LO[SB-1:0] : fsum[SB-1:0];

	assign ra = raddr;

	spef_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ctl.ph1),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ra),
		.rdata (rdata)
	);

	// never-written entries read as zero
	assign s0m = ctl.ok0 ? $signed(rdata) : '0;
	assign s1m = ctl.ok1 ? $signed(rdata) : '0;

	// 256*s0 + (s1 - s0)*f equals s0*(256-f) + s1*f
	assign bdiff   = $signed({s1m[SB-1], s1m}) - $signed({s0_q[SB-1], s0_q});
	assign bprod_w = bdiff * $signed({1'b0, ctl.frac});
	assign acc     = $signed({{3{base_q[SB-1]}}, base_q, 8'd0})
			 + $signed({bprod_q[SB+9], bprod_q}) + BLEND_RND;
	assign wet     = acc[SB+7:8];

	always_ff @(posedge clk) begin
		if (ctl.ph0) begin
			fprod_q <= fprod_w;
		end
		if (ctl.ph1) begin
			s0_q <= s0m;
		end
		if (ctl.blend) begin
			bprod_q <= bprod_w;
			base_q  <= s0_q;
		end
	end

endmodule

[hw/rtl/spef_env.sv]
// Attack/release follower of the mean absolute input level.
// Depends on spef_pkg.
`timescale 1ns / 1ps
module spef_env #(
	parameter int SB = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spef_pkg::lane_ctl_t               ctl,
	input  logic signed [SB-1:0]              l,
	input  logic signed [SB-1:0]              r,
	output logic [spef_pkg::LEVEL_BITS-1:0]   level
);

	localparam int EB  = spef_pkg::ENV_BITS;
	localparam int IW  = SB + 16;
	localparam int DFW = ((IW > EB) ? IW : EB) + 1;
	localparam int PRW = DFW + 18;
	localparam logic signed [PRW-1:0] ENV_RND = PRW'(64'sd1 <<< 23);

	logic signed [SB:0]     le;
	logic signed [SB:0]     re;
	logic [SB:0]            al;
	logic [SB:0]            ar;
	logic [SB:0]            asum;
	logic [IW-1:0]          inl;
	logic signed [DFW-1:0]  diff;
	logic signed [DFW-1:0]  diff_q;
	logic                   atk_q;
	logic signed [17:0]     coef;
	logic signed [PRW-1:0]  prod;
	logic signed [PRW-1:0]  rnd;
	logic signed [PRW-1:0]  sh;
	logic [EB-1:0]          env_q;
	logic [EB-1:0]          env_next;

	assign le   = $signed({l[SB-1], l});
	assign re   = $signed({r[SB-1], r});
	assign al   = le[SB] ? (SB + 1)'(-le) : le;
	assign ar   = re[SB] ? (SB + 1)'(-re) : re;
	assign asum = al + ar;
	assign inl  = {asum, 15'd0};
	assign diff = $signed(DFW'(inl)) - $signed(DFW'(env_q));

	assign coef     = atk_q ? spef_pkg::ATTACK_COEF : spef_pkg::RELEASE_COEF;
	assign prod     = diff_q * coef;
	assign rnd      = prod + ENV_RND;
	assign sh       = rnd >>> 24;
	assign env_next = env_q + sh[EB-1:0];

	// integer part of the tracked level
	assign level = env_q[spef_pkg::ENV_FRAC+spef_pkg::LEVEL_BITS-1:spef_pkg::ENV_FRAC];

	always_ff @(posedge clk) begin
		if (ctl.ph0) begin
			diff_q <= diff;
			atk_q  <= !diff[DFW-1] && (diff != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (ctl.ph1) begin
			env_q <= env_next;
		end
	end

endmodule

[hw/rtl/stereo_predelay_envelope_follower_top.sv]
// Top level of the stereo predelay with level follower: register port,
// read sequencer, fill tracking and output queue. Uses spef_pkg, spef_lane, spef_env.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  input   | in_valid/in_ready  | dry_left, dry_right
//  output  | out_valid/out_ready| wet_left, wet_right, level_envelope
//  config  | APB, pready high   | predelay_q8 @0, cross_gain @4, stereo_enable @8
//
// Each delay store has one read port and every item reads two taps, so the two read
// slots per item set the rate; a new item can be taken in its predecessor's second slot.
// After its read slots, a result is blended and queued for the output. The write pointer
// and a wrap flag mark which entries were ever written, so unwritten taps read as zero
// and no clearing pass runs. A 4-entry output queue absorbs output stalls; in_ready
// drops while 4 items are accepted but not yet delivered.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stereo_predelay_envelope_follower_top #(
	parameter int DELAY_DEPTH = 32768,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_BITS-1:0]       dry_left,
	input  logic signed [SAMPLE_BITS-1:0]       dry_right,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_BITS-1:0]       wet_left,
	output logic signed [SAMPLE_BITS-1:0]       wet_right,
	output logic [spef_pkg::LEVEL_BITS-1:0]     level_envelope,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int SB       = SAMPLE_BITS;
	localparam int AW       = $clog2(DELAY_DEPTH);
	localparam int PW       = AW + 8;              // read position, Q.8
	localparam int PRE_BITS = 23;
	localparam int DW       = (PW > PRE_BITS) ? PW : PRE_BITS;
	localparam logic [DW-1:0] DMIN = DW'(256);
	localparam logic [DW-1:0] DMAX = DW'((DELAY_DEPTH - 3) * 256);
	localparam logic [PW:0]   SPAN = (PW + 1)'(DELAY_DEPTH * 256);
	localparam int QDEPTH   = 4;
	localparam int QA       = $clog2(QDEPTH);
	localparam int QW       = $clog2(QDEPTH + 1);
	localparam int LB       = spef_pkg::LEVEL_BITS;

	typedef enum logic [1:0] {
		REG_PREDELAY = 2'd0,
		REG_XGAIN    = 2'd1,
		REG_STEREO   = 2'd2
	} reg_idx_t;

	// ---------------- register port ----------------
	logic [PRE_BITS-1:0]              pre_q;
	logic [spef_pkg::XGAIN_BITS-1:0]  xgain_q;
	logic                             stereo_q;
	logic                             cfg_wr;
	reg_idx_t                         reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q    <= PRE_BITS'(256);
			xgain_q  <= '0;
			stereo_q <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PREDELAY: pre_q    <= pwdata[PRE_BITS-1:0];
				REG_XGAIN:    xgain_q  <= pwdata[spef_pkg::XGAIN_BITS-1:0];
				REG_STEREO:   stereo_q <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PREDELAY: prdata = 32'(pre_q);
			REG_XGAIN:    prdata = 32'(xgain_q);
			REG_STEREO:   prdata = 32'(stereo_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	logic                       v_s1, ph_q, v_s2, v_s3;
	logic                       ph0, ph1;
	logic                       in_acc, out_acc;
	logic [AW-1:0]              wp_q;
	logic                       full_q;     // store wrapped: every entry written
	logic                       wp_last;
	logic [QW-1:0]              occ_q;      // accepted, not yet delivered
	logic signed [SB-1:0]       l_s1, r_s1;

	assign ph0     = v_s1 && !ph_q;
	assign ph1     = v_s1 && ph_q;
	assign in_ready = (!v_s1 || ph_q) && (occ_q < QW'(QDEPTH));
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign wp_last = (wp_q == AW'(DELAY_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ph_q   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			wp_q   <= '0;
			full_q <= 1'b0;
			occ_q  <= '0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
				ph_q <= 1'b0;
			end else if (ph0) begin
				ph_q <= 1'b1;
			end else if (ph1) begin
				v_s1 <= 1'b0;
				ph_q <= 1'b0;
			end
			v_s2 <= ph1;
			v_s3 <= v_s2;
			if (ph1) begin
				wp_q <= wp_last ? '0 : wp_q + 1'b1;
				if (wp_last) begin
					full_q <= 1'b1;
				end
			end
			if (in_acc && !out_acc) begin
				occ_q <= occ_q + 1'b1;
			end else if (!in_acc && out_acc) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	// mono: right replaced by left for the follower and both pushes
	always_ff @(posedge clk) begin
		if (in_acc) begin
			l_s1 <= dry_left;
			r_s1 <= stereo_q ? dry_right : dry_left;
		end
	end

	// ---------------- tap addresses ----------------
	logic [DW-1:0]  pre_ext, d_c;
	logic [PW:0]    p_raw, p_w;
	logic [AW-1:0]  i0, i1, i1_q, raddr;
	logic [7:0]     frac, frac_s1, frac_s2;
	logic           ok0_q, ok1_s1, ok1_s2;

	assign pre_ext = DW'(pre_q);
	assign d_c     = (pre_ext < DMIN) ? DMIN : ((pre_ext > DMAX) ? DMAX : pre_ext);
	assign p_raw   = {1'b0, wp_q, 8'd0} + SPAN - {1'b0, d_c[PW-1:0]};
	assign p_w     = (p_raw >= SPAN) ? p_raw - SPAN : p_raw;
	assign i0      = p_w[PW-1:8];
	assign frac    = p_w[7:0];
	assign i1      = (i0 == AW'(DELAY_DEPTH - 1)) ? '0 : i0 + 1'b1;
	assign raddr   = ph0 ? i0 : i1_q;

	always_ff @(posedge clk) begin
		if (ph0) begin
			i1_q    <= i1;
			frac_s1 <= frac;
			ok0_q   <= full_q || (i0 < wp_q);
			ok1_s1  <= full_q || (i1 < wp_q);
		end
		if (ph1) begin
			ok1_s2  <= ok1_s1;
			frac_s2 <= frac_s1;
		end
	end

	spef_pkg::lane_ctl_t ctl;
	assign ctl.ph0   = ph0;
	assign ctl.ph1   = ph1;
	assign ctl.blend = v_s2;
	assign ctl.ok0   = ok0_q;
	assign ctl.ok1   = ok1_s2;
	assign ctl.frac  = frac_s2;

	logic signed [SB-1:0] wet_l, wet_r;
	logic [LB-1:0]        level;

	spef_lane #(.DEPTH(DELAY_DEPTH), .SB(SB)) u_lane_l (
		.clk   (clk),
		.ctl   (ctl),
		.raddr (raddr),
		.waddr (wp_q),
		.x     (l_s1),
		.other (r_s1),
		.gain  (xgain_q),
		.wet   (wet_l)
	);

	spef_lane #(.DEPTH(DELAY_DEPTH), .SB(SB)) u_lane_r (
		.clk   (clk),
		.ctl   (ctl),
		.raddr (raddr),
		.waddr (wp_q),
		.x     (r_s1),
		.other (l_s1),
		.gain  (xgain_q),
		.wet   (wet_r)
	);

	spef_env #(.SB(SB)) u_env (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.l      (l_s1),
		.r      (r_s1),
		.level  (level)
	);

	// ---------------- output queue ----------------
	logic signed [SB-1:0] qwl_q [QDEPTH];
	logic signed [SB-1:0] qwr_q [QDEPTH];
	logic [LB-1:0]        qlv_q [QDEPTH];
	logic [QA-1:0]        wr_ptr_q, rd_ptr_q;
	logic [QW-1:0]        cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (v_s3 && !out_acc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!v_s3 && out_acc) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			qwl_q[wr_ptr_q] <= wet_l;
			qwr_q[wr_ptr_q] <= stereo_q ? wet_r : wet_l;
			qlv_q[wr_ptr_q] <= level;
		end
	end

	assign out_valid      = (cnt_q != '0);
	assign wet_left       = qwl_q[rd_ptr_q];
	assign wet_right      = qwr_q[rd_ptr_q];
	assign level_envelope = qlv_q[rd_ptr_q];

	// ---------------- checks ----------------
	`ASSERT_IMPLIES(a_queue_room, v_s3, cnt_q < QW'(QDEPTH), "output queue overflow")
	`ASSERT_IMPLIES(a_read_slot, v_s2, !ph1, "blend overlaps a second read slot")
	`ASSERT_NEXT(a_wp_hold, !ph1, $stable(wp_q), "write pointer moved outside its slot")
	`ASSERT_ALWAYS(a_occ_bound, occ_q <= QW'(QDEPTH), "outstanding item count out of range")

endmodule

[test/stereo_predelay_envelope_follower_top_test.sv]
// Self-checking test of the stereo predelay with level follower: drives dry item pairs,
// writes the registers over APB and checks every wet item against a predictor.
// Depends on spef_pkg and stereo_predelay_envelope_follower_top.
`timescale 1ns / 1ps
module stereo_predelay_envelope_follower_top_test;

	localparam int LINE_DEPTH  = 32768;
	localparam int SMP_BITS    = 24;
	localparam int QUIET_LIMIT = 4000;  // cycles with no handshake before giving up
	localparam int PHASE_ITEMS = 220;
	localparam int NUM_PHASES  = 8;

	// register indexes; byte address is 4 * index
	typedef enum int {
		REG_PREDELAY = 0,
		REG_XGAIN    = 1,
		REG_STEREO   = 2,
		REG_SPARE    = 3   // beyond the register list, must be ignored
	} reg_idx_t;

	localparam logic signed [SMP_BITS-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SMP_BITS-1:0] S_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [SMP_BITS-1:0]          wet_l;
		logic signed [SMP_BITS-1:0]          wet_r;
		logic [spef_pkg::LEVEL_BITS-1:0]     level;
	} wet_frame_t;

	// Predictor plus store of expected wet items. Mirrors the delay lines, write
	// pointer, follower and register file of the block.
	class predelay_scoreboard;
		logic signed [SMP_BITS-1:0] left_line [LINE_DEPTH];
		logic signed [SMP_BITS-1:0] right_line [LINE_DEPTH];
		int unsigned  wr_ptr;
		longint       envelope;
		longint       predelay;
		longint       xgain;
		bit           stereo_on;
		wet_frame_t   wet_queue[$];
		int           errors;
		int           checked;

		function new();
			foreach (left_line[i]) begin
				left_line[i]  = '0;
				right_line[i] = '0;
			end
			wr_ptr    = 0;
			envelope  = 0;
			predelay  = 256;
			xgain     = 0;
			stereo_on = 1'b1;
			errors    = 0;
			checked   = 0;
		endfunction

		function void write_reg(int idx, logic [31:0] val);
			case (idx)
				REG_PREDELAY: predelay = val[22:0];
				REG_XGAIN:    xgain = val[spef_pkg::XGAIN_BITS-1:0];
				REG_STEREO:   stereo_on = val[0];
				default:      ;
			endcase
		endfunction

		// interpolated read behind the write pointer
		function longint tap(bit right_side);
			longint d, p, span, f, s0, s1, acc;
			int unsigned i0, i1;
			span = longint'(LINE_DEPTH) * 256;
			d = predelay;
			if (d < 256) d = 256;
			if (d > longint'(LINE_DEPTH - 3) * 256) d = longint'(LINE_DEPTH - 3) * 256;
			p = longint'(wr_ptr) * 256 + span - d;
			if (p >= span) p -= span;
			i0 = int'(p >> 8) % LINE_DEPTH;
			i1 = (i0 + 1) % LINE_DEPTH;
			f = p & 255;
			s0 = right_side ? right_line[i0] : left_line[i0];
			s1 = right_side ? right_line[i1] : left_line[i1];
			acc = s0 * (256 - f) + s1 * f + 128;
			return acc >>> 8;
		endfunction

		// dry sample plus cross-feed, saturated
		function longint cross_feed(longint x, longint other);
			longint t, s;
			t = ((x - other) * xgain + 32768) >>> 16;
			s = x + t;
			if (s > 64'sd8388607) s = 64'sd8388607;
			if (s < -64'sd8388608) s = -64'sd8388608;
			return s;
		endfunction

		function void accept_dry(logic signed [SMP_BITS-1:0] dl, logic signed [SMP_BITS-1:0] dr);
			longint l, r, inl, coef, wl, wr;
			wet_frame_t fr;
			l = dl;
			r = stereo_on ? longint'(dr) : l;
			inl = ((l < 0 ? -l : l) + (r < 0 ? -r : r)) * 32768;
			coef = (inl > envelope) ? longint'(spef_pkg::ATTACK_COEF) :
				longint'(spef_pkg::RELEASE_COEF);
			envelope = envelope + (((inl - envelope) * coef + (64'sd1 << 23)) >>> 24);
			envelope = envelope & ((64'sd1 << spef_pkg::ENV_BITS) - 1);
			wl = tap(1'b0);
			wr = stereo_on ? tap(1'b1) : wl;
			left_line[wr_ptr]  = SMP_BITS'(cross_feed(l, r));
			right_line[wr_ptr] = SMP_BITS'(cross_feed(r, l));
			wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
			fr.wet_l = wl[SMP_BITS-1:0];
			fr.wet_r = wr[SMP_BITS-1:0];
			fr.level = envelope[spef_pkg::ENV_FRAC +: spef_pkg::LEVEL_BITS];
			wet_queue.push_back(fr);
		endfunction

		function void check_wet(logic signed [SMP_BITS-1:0] wl, logic signed [SMP_BITS-1:0] wr,
				logic [spef_pkg::LEVEL_BITS-1:0] lv);
			wet_frame_t fr;
			if (wet_queue.size() == 0) begin
				$display("%0t: unexpected wet item %0d %0d %0d", $time, wl, wr, lv);
				errors++;
				return;
			end
			fr = wet_queue.pop_front();
			checked++;
			if (fr.wet_l !== wl) begin
				$display("%0t: wet_left expected %0d got %0d", $time, fr.wet_l, wl);
				errors++;
			end
			if (fr.wet_r !== wr) begin
				$display("%0t: wet_right expected %0d got %0d", $time, fr.wet_r, wr);
				errors++;
			end
			if (fr.level !== lv) begin
				$display("%0t: level_envelope expected %0d got %0d", $time, fr.level, lv);
				errors++;
			end
		endfunction

		function int pending();
			return wet_queue.size();
		endfunction
	endclass

	// clock, reset and every block input start at known values
	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic signed [SMP_BITS-1:0]  dry_left  = '0;
	logic signed [SMP_BITS-1:0]  dry_right = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [SMP_BITS-1:0]  wet_left;
	logic signed [SMP_BITS-1:0]  wet_right;
	logic [spef_pkg::LEVEL_BITS-1:0] level_envelope;
	logic                        psel      = 1'b0;
	logic                        penable   = 1'b0;
	logic                        pwrite    = 1'b0;
	logic [3:0]                  paddr     = '0;
	logic [31:0]                 pwdata    = '0;
	logic [31:0]                 prdata;
	logic                        pready;

	predelay_scoreboard sb;
	int idle_pct    = 0;    // chance in a hundred that the sender idles a cycle
	int stall_pct   = 0;    // chance in a hundred that the receiver stalls a cycle
	int quiet_cycles = 0;
	int settings    = 0;
	int sent        = 0;

	stereo_predelay_envelope_follower_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.dry_left(dry_left), .dry_right(dry_right),
		.out_valid(out_valid), .out_ready(out_ready),
		.wet_left(wet_left), .wet_right(wet_right), .level_envelope(level_envelope),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// Output side: values are read in the active region of the edge, so they are the
	// ones the flops held at the edge. out_ready gets one fresh NBA per edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_wet(wet_left, wet_right, level_envelope);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// nothing accepted for too long: the block has hung
	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One dry item. Idle cycles drop valid first; once raised, valid stays up with
	// the payload held until the item is taken. After acceptance valid is left high
	// so back-to-back items need no second NBA in the same step.
	task automatic send_dry(logic signed [SMP_BITS-1:0] l, logic signed [SMP_BITS-1:0] r);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		dry_left  <= l;
		dry_right <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.accept_dry(l, r);
		sent++;
	endtask

	// sender holds off until every expected wet item is out
	task automatic drain_wet();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// APB write: setup, access (register taken at this edge), then release the bus
	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(int'(idx) * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// mostly full-range noise, with rails, silence and quiet stretches for the release
	function automatic logic signed [SMP_BITS-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 9))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return '0;
			3, 4: begin
				v = $urandom_range(0, 511);
				return SMP_BITS'(v - 256);
			end
			default: return SMP_BITS'($urandom);
		endcase
	endfunction

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one sample back, no cross-feed, stereo
		send_dry(S_MAX, S_MIN);
		send_dry(S_MIN, S_MAX);
		send_dry('0, '0);
		send_dry(-24'sd1, 24'sd1);
		send_dry(S_MAX, S_MAX);
		send_dry(S_MIN, S_MIN);

		// predelay below the clamp, cross gain far above its range: sums saturate,
		// and a write past the register list must change nothing
		drain_wet();
		apb_write(REG_PREDELAY, 32'd0);
		apb_write(REG_XGAIN, 32'hFFFF_FFFF);
		apb_write(REG_SPARE, 32'hFFFF_FFFF);
		settings++;
		send_dry(S_MAX, S_MIN);
		send_dry(S_MIN, S_MAX);
		send_dry(S_MAX, S_MIN);
		send_dry(S_MIN, S_MAX);
		send_dry(24'sd123456, -24'sd654321);

		// one-and-a-half-sample delay in mono: right input ignored
		drain_wet();
		apb_write(REG_PREDELAY, 32'd384);
		apb_write(REG_STEREO, 32'd0);
		settings++;
		send_dry(S_MAX, S_MIN);
		send_dry(S_MIN, 24'sd7);
		send_dry(-24'sd1, S_MAX);
		send_dry('0, S_MIN);

		// longest legal delay, then a value past the upper clamp
		drain_wet();
		apb_write(REG_STEREO, 32'd1);
		apb_write(REG_PREDELAY, 32'd8387840);
		settings++;
		send_dry(S_MAX, S_MIN);
		send_dry(S_MIN, S_MAX);
		drain_wet();
		apb_write(REG_PREDELAY, 32'h007F_FFFF);
		apb_write(REG_XGAIN, 32'd11796);
		settings++;
		send_dry(S_MAX, '0);
		send_dry('0, S_MIN);

		// smallest fraction above one sample
		drain_wet();
		apb_write(REG_PREDELAY, 32'd257);
		apb_write(REG_XGAIN, 32'd0);
		settings++;
		repeat (3) send_dry(pick_sample(), pick_sample());

		// random phases cycle through the idling patterns; each one starts from an
		// idle block with fresh register values, mostly short delays so reads land
		// on written entries, now and then a long or out-of-range one
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_wet();
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 23; stall_pct = 23; end
			endcase
			if ($urandom_range(0, 3) != 0)
				apb_write(REG_PREDELAY, $urandom_range(0, 64 * 256));
			else
				apb_write(REG_PREDELAY, $urandom);
			if ($urandom_range(0, 3) != 0)
				apb_write(REG_XGAIN, $urandom_range(0, 11796));
			else
				apb_write(REG_XGAIN, $urandom_range(11797, 16383));
			apb_write(REG_STEREO, $urandom_range(0, 1));
			settings++;
			repeat (PHASE_ITEMS) send_dry(pick_sample(), pick_sample());
		end

		// let the last wet items out, then wait for anything stray
		drain_wet();
		repeat (12) @(posedge clk);

		$display("Run covered %0d dry items and %0d wet checks over %0d register settings,",
			sent, sb.checked, settings);
		$display("stereo and mono, clamped delays, saturating cross-feed and four idling patterns.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
